// File: rtl/pms_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pms_pkg: shared types and constants of the particle motion step block
// Word formats, item structs, register indexes and saturation helpers.
// ----------------------------------------------------------------------------
package pms_pkg;

	localparam int WORD_W     = 32;
	localparam int FRAC_W     = 16;
	localparam int WIDE_W     = 56;
	localparam int PROD_W     = 2 * WORD_W;
	localparam int ROOT_W     = WORD_W;
	localparam int QUO_W      = 52;
	localparam int FMAG_W     = 35;
	localparam int EDGE_W     = 36;
	localparam int DIV_STEPS  = PROD_W;
	localparam int DIV_CNT_W  = $clog2(DIV_STEPS);
	localparam int SQRT_STEPS = ROOT_W;
	localparam int SQRT_CNT_W = $clog2(SQRT_STEPS);
	localparam int QDEPTH     = 2;
	localparam int QPTR_W     = $clog2(QDEPTH);
	localparam int CFG_DATA_W = 31;
	localparam int CFG_IDX_W  = 3;
	localparam int SPRING_GAIN = 10;

	localparam logic [1:0] MODE_FORCE = 2'd0;
	localparam logic [1:0] MODE_TICK  = 2'd1;
	localparam logic [1:0] MODE_LOAD  = 2'd2;

	localparam logic [1:0] BOUND_WRAP   = 2'd0;
	localparam logic [1:0] BOUND_BOUNCE = 2'd1;
	localparam logic [1:0] BOUND_SPRING = 2'd2;

	localparam logic [CFG_IDX_W-1:0] REG_BOUND_MODE   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_SPEED    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_DECAY_FACTOR = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_EDGE_RADIUS  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_FIELD_WIDTH  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_FIELD_HEIGHT = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_BODY_WEIGHT  = 3'd6;

	typedef logic signed [WORD_W-1:0] word_t;

	typedef struct packed {
		logic [1:0] mode;
		word_t      value_x;
		word_t      value_y;
		word_t      load_vel_x;
		word_t      load_vel_y;
	} in_item_t;

	typedef struct packed {
		word_t pos_x;
		word_t pos_y;
		word_t vel_x;
		word_t vel_y;
	} out_item_t;

	typedef enum logic [1:0] {
		OP_FORCE = 2'd0,
		OP_TICK  = 2'd1,
		OP_LOAD  = 2'd2
	} op_t;

	typedef struct packed {
		op_t   op;
		word_t value_x;
		word_t value_y;
		word_t load_vel_x;
		word_t load_vel_y;
	} work_item_t;

	typedef struct packed {
		logic [1:0]  bound_mode;
		logic [30:0] max_speed;
		logic [16:0] decay_factor;
		logic [9:0]  edge_radius;
		logic [12:0] field_width;
		logic [12:0] field_height;
		logic [30:0] body_weight;
	} cfg_t;

	// Clamp a wide signed value to the signed word range.
	function automatic word_t sat_word(input logic signed [WIDE_W-1:0] v);
		logic same;
		same = (v[WIDE_W-1:WORD_W-1] == '0) || (v[WIDE_W-1:WORD_W-1] == '1);
		if (same) begin
			return $signed(v[WORD_W-1:0]);
		end else if (v[WIDE_W-1]) begin
			return $signed({1'b1, {(WORD_W-1){1'b0}}});
		end else begin
			return $signed({1'b0, {(WORD_W-1){1'b1}}});
		end
	endfunction

	// Magnitude of a signed word, exact for the most negative value.
	function automatic logic [WORD_W-1:0] magn(input word_t v);
		logic [WORD_W-1:0] m;
		m = v;
		return v[WORD_W-1] ? (~m + 1'b1) : m;
	endfunction

endpackage

// File: rtl/pms_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pms_front: request intake
// Accepts requests, classifies the mode, drops unknown modes and queues work.
// ----------------------------------------------------------------------------
module pms_front import pms_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  in_item_t   in_item,
	output logic       q_valid,
	input  logic       q_pop,
	output work_item_t q_entry
);

	work_item_t        slot_q [QDEPTH];
	logic [QPTR_W-1:0] wr_q;
	logic [QPTR_W-1:0] rd_q;
	logic [QPTR_W:0]   cnt_q;
	logic              keep;
	op_t               op;
	logic              push;
	logic              pop;

	always_comb begin
		keep = 1'b1;
		op   = OP_FORCE;
		unique case (in_item.mode)
			MODE_FORCE: op = OP_FORCE;
			MODE_TICK:  op = OP_TICK;
			MODE_LOAD:  op = OP_LOAD;
			default:    keep = 1'b0;
		endcase
	end

	assign in_ready = (cnt_q != (QPTR_W+1)'(QDEPTH));
	assign q_valid  = (cnt_q != '0);
	assign q_entry  = slot_q[rd_q];
	assign push     = in_valid && in_ready && keep;
	assign pop      = q_pop && q_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= rd_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_q] <= '{op: op, value_x: in_item.value_x, value_y: in_item.value_y,
				load_vel_x: in_item.load_vel_x, load_vel_y: in_item.load_vel_y};
		end
	end

endmodule

// File: rtl/pms_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pms_div: restoring divider
// Divides a wide dividend by a word divisor, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module pms_div import pms_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [PROD_W-1:0] num,
	input  logic [WORD_W-1:0] den,
	output logic [PROD_W-1:0] quo,
	output logic              done
);

	logic [WORD_W-1:0]    rem_q;
	logic [WORD_W-1:0]    den_q;
	logic [PROD_W-1:0]    quo_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic                 busy_q;
	logic                 done_q;
	logic [WORD_W:0]      trial;
	logic [WORD_W:0]      diff;
	logic                 ge;

	assign trial = {rem_q, quo_q[PROD_W-1]};
	assign diff  = trial - {1'b0, den_q};
	assign ge    = (trial >= {1'b0, den_q});
	assign quo   = quo_q;
	assign done  = done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == DIV_CNT_W'(DIV_STEPS - 1));
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == DIV_CNT_W'(DIV_STEPS - 1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			den_q <= den;
			quo_q <= num;
		end else if (busy_q) begin
			rem_q <= ge ? diff[WORD_W-1:0] : trial[WORD_W-1:0];
			quo_q <= {quo_q[PROD_W-2:0], ge};
		end
	end

endmodule

// File: rtl/pms_sqrt.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pms_sqrt: integer square root
// Digit-by-digit floor square root, one root bit per cycle.
// ----------------------------------------------------------------------------
module pms_sqrt import pms_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [PROD_W-1:0] rad,
	output logic [ROOT_W-1:0] root,
	output logic              done
);

	logic [PROD_W-1:0]     rad_q;
	logic [ROOT_W+1:0]     rem_q;
	logic [ROOT_W-1:0]     root_q;
	logic [SQRT_CNT_W-1:0] cnt_q;
	logic                  busy_q;
	logic                  done_q;
	logic [ROOT_W+1:0]     rem_sh;
	logic [ROOT_W+1:0]     trial;
	logic                  ge;

	assign rem_sh = {rem_q[ROOT_W-1:0], rad_q[PROD_W-1 -: 2]};
	assign trial  = {root_q, 2'b01};
	assign ge     = (rem_sh >= trial);
	assign root   = root_q;
	assign done   = done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == SQRT_CNT_W'(SQRT_STEPS - 1));
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == SQRT_CNT_W'(SQRT_STEPS - 1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rad_q  <= rad;
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			rad_q  <= {rad_q[PROD_W-3:0], 2'b00};
			rem_q  <= ge ? (rem_sh - trial) : rem_sh;
			root_q <= {root_q[ROOT_W-2:0], ge};
		end
	end

endmodule

// File: rtl/pms_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pms_back: integration sequencer
// Holds body state and runs force, tick and load work on shared arithmetic.
// ----------------------------------------------------------------------------
module pms_back import pms_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  cfg_t       cfg,
	input  logic       q_valid,
	output logic       q_pop,
	input  work_item_t q_entry,
	output logic       out_valid,
	input  logic       out_ready,
	output out_item_t  out_item
);

	typedef enum logic [18:0] {
		S_IDLE   = 19'd1 << 0,
		S_FRC_Y  = 19'd1 << 1,
		S_VEL    = 19'd1 << 2,
		S_MUL_X  = 19'd1 << 3,
		S_MUL_Y  = 19'd1 << 4,
		S_MUL_M  = 19'd1 << 5,
		S_CMP    = 19'd1 << 6,
		S_SQRT   = 19'd1 << 7,
		S_SCL_X  = 19'd1 << 8,
		S_SCL_Y  = 19'd1 << 9,
		S_DIVGO  = 19'd1 << 10,
		S_DIVW   = 19'd1 << 11,
		S_POS    = 19'd1 << 12,
		S_DEC_X  = 19'd1 << 13,
		S_DEC_Y  = 19'd1 << 14,
		S_DEC_W  = 19'd1 << 15,
		S_EDGE_X = 19'd1 << 16,
		S_EDGE_Y = 19'd1 << 17,
		S_OUT    = 19'd1 << 18
	} state_t;

	typedef enum logic [2:0] {
		DOP_VX = 3'd0,
		DOP_VY = 3'd1,
		DOP_FX = 3'd2,
		DOP_FY = 3'd3,
		DOP_EX = 3'd4,
		DOP_EY = 3'd5
	} dop_t;

	state_t state_q;
	dop_t   dop_q;
	word_t  pos_x_q, pos_y_q, spd_x_q, spd_y_q, acc_x_q, acc_y_q;
	logic   out_valid_q;

	out_item_t         out_item_q;
	logic [PROD_W-1:0] prod_q;
	logic [PROD_W-1:0] sum_q;
	logic [WORD_W-1:0] len_q;
	logic [FMAG_W-1:0] fmag_q;
	logic              fneg_q;
	word_t             fy_q;

	logic [WORD_W-1:0] mx, my, ax, ay, ms;
	logic [WORD_W-1:0] mul_a, mul_b;
	logic [PROD_W-1:0] prod_d;
	logic              out_free;

	logic              div_start, div_vel, div_done;
	logic [PROD_W-1:0] div_num, div_quo;
	logic [WORD_W-1:0] div_den;
	logic              sqrt_start, sqrt_done;
	logic [ROOT_W-1:0] sqrt_root;

	logic [WORD_W-1:0]       vq;
	logic                    vel_neg;
	word_t                   vel_new;
	logic signed [WIDE_W-1:0] push_q, push_sum;
	word_t                   push_acc, push_val;
	logic [WORD_W-1:0]       dec_m;
	logic                    dec_neg;
	logic signed [WIDE_W-1:0] dec_w;
	word_t                   dec_val;

	logic                    edge_y;
	word_t                   e_pin, e_vin;
	logic signed [EDGE_W-1:0] e_p, e_v, e_size, e_r;
	logic signed [EDGE_W-1:0] e_p1, e_p2, e_v1, e_v2, e_dist, e_spring;
	logic                    e_c1, e_c2, e_gt;
	logic                    edge_push;
	word_t                   edge_p, edge_v;

	assign mx = magn(spd_x_q);
	assign my = magn(spd_y_q);
	assign ax = magn(acc_x_q);
	assign ay = magn(acc_y_q);
	assign ms = {1'b0, cfg.max_speed};

	// Shared multiplier operands
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			S_MUL_X: begin mul_a = mx; mul_b = mx; end
			S_MUL_Y: begin mul_a = my; mul_b = my; end
			S_MUL_M: begin mul_a = ms; mul_b = ms; end
			S_SCL_X: begin mul_a = mx; mul_b = ms; end
			S_SCL_Y: begin mul_a = my; mul_b = ms; end
			S_DEC_X: begin mul_a = ax; mul_b = WORD_W'(cfg.decay_factor); end
			S_DEC_Y: begin mul_a = ay; mul_b = WORD_W'(cfg.decay_factor); end
			default: ;
		endcase
	end

	assign prod_d = PROD_W'(mul_a) * PROD_W'(mul_b);

	assign div_start = (state_q == S_DIVGO);
	assign div_vel   = (dop_q == DOP_VX) || (dop_q == DOP_VY);
	assign div_num   = div_vel ? prod_q
		: {{(PROD_W-FMAG_W-FRAC_W){1'b0}}, fmag_q, {FRAC_W{1'b0}}};
	assign div_den   = div_vel ? len_q
		: ((cfg.body_weight == '0) ? WORD_W'(1) : {1'b0, cfg.body_weight});

	assign sqrt_start = (state_q == S_CMP) && (sum_q > prod_q);

	pms_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (div_den),
		.quo    (div_quo),
		.done   (div_done)
	);

	pms_sqrt u_sqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (sqrt_start),
		.rad    (sum_q),
		.root   (sqrt_root),
		.done   (sqrt_done)
	);

	// Rescaled velocity component
	always_comb begin
		vq      = div_quo[WORD_W-1:0];
		vel_neg = (dop_q == DOP_VX) ? spd_x_q[WORD_W-1] : spd_y_q[WORD_W-1];
		vel_new = $signed(vel_neg ? (~vq + 1'b1) : vq);
	end

	// Force quotient added into acceleration
	always_comb begin
		push_q   = {{(WIDE_W-QUO_W){1'b0}}, div_quo[QUO_W-1:0]};
		push_acc = ((dop_q == DOP_FX) || (dop_q == DOP_EX)) ? acc_x_q : acc_y_q;
		push_sum = WIDE_W'(push_acc) + (fneg_q ? -push_q : push_q);
		push_val = sat_word(push_sum);
	end

	// Acceleration decay
	always_comb begin
		dec_m   = prod_q[FRAC_W +: WORD_W];
		dec_neg = (state_q == S_DEC_Y) ? acc_x_q[WORD_W-1] : acc_y_q[WORD_W-1];
		dec_w   = {{(WIDE_W-WORD_W){1'b0}}, dec_m};
		if (dec_neg) begin
			dec_w = -dec_w;
		end
		dec_val = sat_word(dec_w);
	end

	// Edge rule for the axis in progress
	always_comb begin
		edge_y = (state_q == S_EDGE_Y);
		e_pin  = edge_y ? pos_y_q : pos_x_q;
		e_vin  = edge_y ? spd_y_q : spd_x_q;
		e_p    = EDGE_W'(e_pin);
		e_v    = EDGE_W'(e_vin);
		e_size = EDGE_W'({edge_y ? cfg.field_height : cfg.field_width, {FRAC_W{1'b0}}});
		e_r    = EDGE_W'({cfg.edge_radius, {FRAC_W{1'b0}}});
		e_p1 = e_p;
		e_p2 = e_p;
		e_v1 = e_v;
		e_v2 = e_v;
		e_c1 = 1'b0;
		e_c2 = 1'b0;
		e_gt = (e_p > e_size);
		e_dist = e_gt ? (e_p - e_size) : -e_p;
		e_spring = e_dist * EDGE_W'(SPRING_GAIN);
		edge_push = 1'b0;
		case (cfg.bound_mode)
			BOUND_WRAP: begin
				e_p1 = (e_p > e_size + e_r) ? -e_r : e_p;
				e_p2 = (e_p1 < -e_r) ? (e_size + e_r) : e_p1;
			end
			BOUND_BOUNCE: begin
				e_c1 = (e_p > e_size - e_r);
				if (e_c1) begin
					e_v1 = EDGE_W'(sat_word(WIDE_W'(-e_v)));
					e_p1 = EDGE_W'(sat_word(WIDE_W'(((e_size - e_r) <<< 1) - e_p)));
				end
				e_v2 = e_v1;
				e_p2 = e_p1;
				e_c2 = (e_p1 < e_r);
				if (e_c2) begin
					e_v2 = EDGE_W'(sat_word(WIDE_W'(-e_v1)));
					e_p2 = EDGE_W'(sat_word(WIDE_W'((e_r <<< 1) - e_p1)));
				end
			end
			BOUND_SPRING: edge_push = e_gt || e_p[EDGE_W-1];
			default: ;
		endcase
		edge_p = $signed(e_p2[WORD_W-1:0]);
		edge_v = $signed(e_v2[WORD_W-1:0]);
	end

	assign out_free  = !out_valid_q || out_ready;
	assign q_pop     = (state_q == S_IDLE) && q_valid;
	assign out_valid = out_valid_q;
	assign out_item  = out_item_q;

	// Sequencer and body state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			dop_q       <= DOP_FX;
			pos_x_q     <= '0;
			pos_y_q     <= '0;
			spd_x_q     <= '0;
			spd_y_q     <= '0;
			acc_x_q     <= '0;
			acc_y_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if ((state_q == S_OUT) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (q_valid) begin
						unique case (q_entry.op)
							OP_FORCE: begin
								dop_q   <= DOP_FX;
								state_q <= S_DIVGO;
							end
							OP_TICK: state_q <= S_VEL;
							OP_LOAD: begin
								pos_x_q <= q_entry.value_x;
								pos_y_q <= q_entry.value_y;
								spd_x_q <= q_entry.load_vel_x;
								spd_y_q <= q_entry.load_vel_y;
							end
							default: ;
						endcase
					end
				end
				S_FRC_Y: begin
					dop_q   <= DOP_FY;
					state_q <= S_DIVGO;
				end
				S_VEL: begin
					spd_x_q <= sat_word(WIDE_W'(spd_x_q) + WIDE_W'(acc_x_q));
					spd_y_q <= sat_word(WIDE_W'(spd_y_q) + WIDE_W'(acc_y_q));
					state_q <= S_MUL_X;
				end
				S_MUL_X: state_q <= S_MUL_Y;
				S_MUL_Y: state_q <= S_MUL_M;
				S_MUL_M: state_q <= S_CMP;
				S_CMP:   state_q <= (sum_q > prod_q) ? S_SQRT : S_POS;
				S_SQRT: begin
					if (sqrt_done) begin
						dop_q   <= DOP_VX;
						state_q <= S_SCL_X;
					end
				end
				S_SCL_X: state_q <= S_DIVGO;
				S_SCL_Y: state_q <= S_DIVGO;
				S_DIVGO: state_q <= S_DIVW;
				S_DIVW: begin
					if (div_done) begin
						unique case (dop_q)
							DOP_VX: begin
								spd_x_q <= vel_new;
								dop_q   <= DOP_VY;
								state_q <= S_SCL_Y;
							end
							DOP_VY: begin
								spd_y_q <= vel_new;
								state_q <= S_POS;
							end
							DOP_FX: begin
								acc_x_q <= push_val;
								state_q <= S_FRC_Y;
							end
							DOP_FY: begin
								acc_y_q <= push_val;
								state_q <= S_IDLE;
							end
							DOP_EX: begin
								acc_x_q <= push_val;
								state_q <= S_EDGE_Y;
							end
							DOP_EY: begin
								acc_y_q <= push_val;
								state_q <= S_OUT;
							end
							default: state_q <= S_IDLE;
						endcase
					end
				end
				S_POS: begin
					pos_x_q <= sat_word(WIDE_W'(pos_x_q) + WIDE_W'(spd_x_q));
					pos_y_q <= sat_word(WIDE_W'(pos_y_q) + WIDE_W'(spd_y_q));
					state_q <= S_DEC_X;
				end
				S_DEC_X: state_q <= S_DEC_Y;
				S_DEC_Y: begin
					acc_x_q <= dec_val;
					state_q <= S_DEC_W;
				end
				S_DEC_W: begin
					acc_y_q <= dec_val;
					state_q <= S_EDGE_X;
				end
				S_EDGE_X: begin
					pos_x_q <= edge_p;
					spd_x_q <= edge_v;
					if (edge_push) begin
						dop_q   <= DOP_EX;
						state_q <= S_DIVGO;
					end else begin
						state_q <= S_EDGE_Y;
					end
				end
				S_EDGE_Y: begin
					pos_y_q <= edge_p;
					spd_y_q <= edge_v;
					if (edge_push) begin
						dop_q   <= DOP_EY;
						state_q <= S_DIVGO;
					end else begin
						state_q <= S_OUT;
					end
				end
				S_OUT: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Working data
	always_ff @(posedge clk) begin
		prod_q <= prod_d;
		case (state_q)
			S_IDLE: begin
				fmag_q <= FMAG_W'(magn(q_entry.value_x));
				fneg_q <= q_entry.value_x[WORD_W-1];
				fy_q   <= q_entry.value_y;
			end
			S_FRC_Y: begin
				fmag_q <= FMAG_W'(magn(fy_q));
				fneg_q <= fy_q[WORD_W-1];
			end
			S_MUL_Y: sum_q <= prod_q;
			S_MUL_M: sum_q <= sum_q + prod_q;
			S_SQRT: begin
				if (sqrt_done) begin
					len_q <= (sqrt_root == '0) ? WORD_W'(1) : sqrt_root;
				end
			end
			S_EDGE_X, S_EDGE_Y: begin
				fmag_q <= e_spring[FMAG_W-1:0];
				fneg_q <= e_gt;
			end
			S_OUT: begin
				if (out_free) begin
					out_item_q <= '{pos_x: pos_x_q, pos_y: pos_y_q,
						vel_x: spd_x_q, vel_y: spd_y_q};
				end
			end
			default: ;
		endcase
	end

endmodule

// File: rtl/particle_motion_step_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// particle_motion_step_top: 2D point-body integrator
// Q16.16 position, velocity and acceleration with speed limit and edges.
// ----------------------------------------------------------------------------
// Usage:
//  - Input channel (in_valid/in_ready/in_item): one request per handshake.
//    mode 0 adds force/weight to acceleration, mode 1 runs one tick,
//    mode 2 loads position and velocity, mode 3 is dropped on entry.
//  - Output channel (out_valid/out_ready/out_item): one result per tick,
//    holding position and velocity after the tick. Force and load give none.
//  - Config port: cfg_we writes cfg_wdata into register cfg_index at the
//    clock edge; write only while no request is in flight.
//  - Requests enter a two-deep queue and run one at a time on a sequencer
//    that shares one 32x32 multiplier, a 64-step divider and a 32-step root.
//  - Work per request: load writes the state directly; a tick runs the
//    root and two divides only when the speed limit engages, plus one
//    divide per axis on which the inertial spring pushes; force runs
//    two divides. The divider gives one quotient bit per cycle.
//  - A finished tick waits in the output register; while the receiver
//    stalls, the queue still takes requests until it is full.
//  - Reset clears body state to zero and loads register defaults.
// ----------------------------------------------------------------------------
module particle_motion_step_top import pms_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  in_item_t              in_item,
	output logic                  out_valid,
	input  logic                  out_ready,
	output out_item_t             out_item,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata
);

	localparam logic [30:0] MAX_SPEED_RST = 31'd262144;
	localparam logic [16:0] DECAY_RST     = 17'd65536;
	localparam logic [12:0] WIDTH_RST     = 13'd1024;
	localparam logic [12:0] HEIGHT_RST    = 13'd768;
	localparam logic [30:0] WEIGHT_RST    = 31'd65536;

	cfg_t       cfg_q;
	logic       q_valid;
	logic       q_pop;
	work_item_t q_entry;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.bound_mode   <= BOUND_WRAP;
			cfg_q.max_speed    <= MAX_SPEED_RST;
			cfg_q.decay_factor <= DECAY_RST;
			cfg_q.edge_radius  <= '0;
			cfg_q.field_width  <= WIDTH_RST;
			cfg_q.field_height <= HEIGHT_RST;
			cfg_q.body_weight  <= WEIGHT_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_BOUND_MODE:   cfg_q.bound_mode   <= cfg_wdata[1:0];
				REG_MAX_SPEED:    cfg_q.max_speed    <= cfg_wdata[30:0];
				REG_DECAY_FACTOR: cfg_q.decay_factor <= cfg_wdata[16:0];
				REG_EDGE_RADIUS:  cfg_q.edge_radius  <= cfg_wdata[9:0];
				REG_FIELD_WIDTH:  cfg_q.field_width  <= cfg_wdata[12:0];
				REG_FIELD_HEIGHT: cfg_q.field_height <= cfg_wdata[12:0];
				REG_BODY_WEIGHT:  cfg_q.body_weight  <= cfg_wdata[30:0];
				default: ;
			endcase
		end
	end

	// Intake: classify and queue
	pms_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_item  (in_item),
		.q_valid  (q_valid),
		.q_pop    (q_pop),
		.q_entry  (q_entry)
	);

	// Execution: state, arithmetic, output register
	pms_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.q_valid   (q_valid),
		.q_pop     (q_pop),
		.q_entry   (q_entry),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_item  (out_item)
	);

	// Pop only from a non-empty queue
	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> q_valid)
		else $error("queue popped while empty");

	// A full queue holds work
	a_full_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> q_valid)
		else $error("queue full but reports no entry");

	// The queue fills only through an accepted request
	a_fill_by_accept: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(in_ready) |-> $past(in_valid))
		else $error("queue filled without a request");

endmodule

// File: bench/tb_particle_motion_step_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_particle_motion_step_top: self-checking bench of the particle motion step
// Drives force, tick, load and dropped requests under many register settings
// and idle patterns, and checks every tick result against a bit-exact model.
// ----------------------------------------------------------------------------
module tb_particle_motion_step_top import pms_pkg::*; ();

	localparam int    CLK_HI    = 6;
	localparam int    CLK_LO    = 6;
	localparam int    DRAIN_CYC = 600;
	localparam int    N_PHASES  = 8;
	localparam int    PER_PHASE = 66;
	localparam longint unsigned QUOT_CAP = 64'd1 << 62;

	logic                  clk;
	logic                  arst_n;
	logic                  in_valid;
	logic                  in_ready;
	in_item_t              in_item;
	logic                  out_valid;
	logic                  out_ready;
	out_item_t             out_item;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_wdata;

	particle_motion_step_top dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_item(in_item),
		.out_valid(out_valid), .out_ready(out_ready), .out_item(out_item),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
	);

	always begin
		clk = 1'b1;
		#(CLK_HI);
		clk = 1'b0;
		#(CLK_LO);
	end

	// Body state and register copy of the motion model
	longint body_px, body_py, body_vx, body_vy, body_ax, body_ay;
	longint unsigned r_bound, r_vmax, r_decay, r_radius, r_width, r_height, r_weight;

	out_item_t pending_motion[$];
	int        fail_count;
	int        send_idle_pct;
	int        stall_pct;

	function automatic longint sat32(input longint v);
		if (v > 64'sd2147483647) return 64'sd2147483647;
		if (v < -64'sd2147483648) return -64'sd2147483648;
		return v;
	endfunction

	function automatic longint unsigned abs64(input longint v);
		return v < 0 ? longint'(-v) : longint'(v);
	endfunction

	// trunc(m * k / d), capped at 2^62
	function automatic longint unsigned scaled_quot(input longint unsigned m,
			input longint unsigned k, input longint unsigned d);
		logic [127:0] prod;
		logic [127:0] q;
		prod = 128'(m) * 128'(k);
		q = prod / 128'(d);
		if (q > 128'(QUOT_CAP)) return QUOT_CAP;
		return q[63:0];
	endfunction

	function automatic void add_force(inout longint acc, input longint f);
		longint unsigned d;
		longint unsigned q;
		d = (r_weight == 0) ? 64'd1 : r_weight;
		q = scaled_quot(abs64(f), 64'd1 << FRAC_W, d);
		acc = sat32(acc + ((f < 0) ? -longint'(q) : longint'(q)));
	endfunction

	function automatic longint unsigned root_floor(input logic [127:0] s);
		logic [127:0] r;
		logic [127:0] c;
		r = '0;
		for (int b = 62; b >= 0; b--) begin
			c = r | (128'd1 << b);
			if (c * c <= s) r = c;
		end
		return r[63:0];
	endfunction

	function automatic void clamp_speed();
		longint unsigned mx, my, len, qx, qy;
		logic [127:0] sq;
		mx = abs64(body_vx);
		my = abs64(body_vy);
		sq = 128'(mx) * 128'(mx) + 128'(my) * 128'(my);
		if (sq <= 128'(r_vmax) * 128'(r_vmax)) return;
		len = root_floor(sq);
		if (len == 0) len = 1;
		qx = scaled_quot(mx, r_vmax, len);
		qy = scaled_quot(my, r_vmax, len);
		body_vx = (body_vx < 0) ? -longint'(qx) : longint'(qx);
		body_vy = (body_vy < 0) ? -longint'(qy) : longint'(qy);
	endfunction

	function automatic longint decay_accel(input longint a);
		longint unsigned m;
		m = (abs64(a) * r_decay) >> 16;
		return sat32((a < 0) ? -longint'(m) : longint'(m));
	endfunction

	function automatic void edge_rule(inout longint p, inout longint v, inout longint a,
			input longint size);
		longint r;
		r = longint'(r_radius) << FRAC_W;
		case (r_bound[1:0])
			BOUND_WRAP: begin
				if (p > size + r) p = sat32(-r);
				if (p < -r) p = sat32(size + r);
			end
			BOUND_BOUNCE: begin
				if (p > size - r) begin
					v = sat32(-v);
					p = sat32(2 * (size - r) - p);
				end
				if (p < r) begin
					v = sat32(-v);
					p = sat32(2 * r - p);
				end
			end
			BOUND_SPRING: begin
				if (p > size) add_force(a, -SPRING_GAIN * (p - size));
				if (p < 0) add_force(a, SPRING_GAIN * (-p));
			end
			default: ;
		endcase
	endfunction

	// Advance the body by one request; return 1 when a tick result is due
	function automatic bit step_body(input in_item_t it, output out_item_t res);
		res = '0;
		case (it.mode)
			MODE_FORCE: begin
				add_force(body_ax, longint'(it.value_x));
				add_force(body_ay, longint'(it.value_y));
				return 1'b0;
			end
			MODE_LOAD: begin
				body_px = longint'(it.value_x);
				body_py = longint'(it.value_y);
				body_vx = longint'(it.load_vel_x);
				body_vy = longint'(it.load_vel_y);
				return 1'b0;
			end
			MODE_TICK: begin
				body_vx = sat32(body_vx + body_ax);
				body_vy = sat32(body_vy + body_ay);
				clamp_speed();
				body_px = sat32(body_px + body_vx);
				body_py = sat32(body_py + body_vy);
				body_ax = decay_accel(body_ax);
				body_ay = decay_accel(body_ay);
				edge_rule(body_px, body_vx, body_ax, longint'(r_width) << FRAC_W);
				edge_rule(body_py, body_vy, body_ay, longint'(r_height) << FRAC_W);
				res.pos_x = word_t'(body_px);
				res.pos_y = word_t'(body_py);
				res.vel_x = word_t'(body_vx);
				res.vel_y = word_t'(body_vy);
				return 1'b1;
			end
			default: return 1'b0;
		endcase
	endfunction

	// Drop valid so that no stale request is taken during a pause
	task automatic hold_input();
		@(negedge clk);
		in_valid = 1'b0;
	endtask

	// Offer one request, with random gaps, and predict it once it is taken
	task automatic send_request(input in_item_t it, input bit typed, input out_item_t typed_res);
		out_item_t res;
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		in_valid = 1'b1;
		in_item = it;
		do @(posedge clk); while (!in_ready);
		if (step_body(it, res))
			pending_motion.push_back(typed ? typed_res : res);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input longint unsigned val);
		@(negedge clk);
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_wdata = val[CFG_DATA_W-1:0];
		case (idx)
			REG_BOUND_MODE:   r_bound  = val & 64'h3;
			REG_MAX_SPEED:    r_vmax   = val & 64'h7FFF_FFFF;
			REG_DECAY_FACTOR: r_decay  = val & 64'h1_FFFF;
			REG_EDGE_RADIUS:  r_radius = val & 64'h3FF;
			REG_FIELD_WIDTH:  r_width  = val & 64'h1FFF;
			REG_FIELD_HEIGHT: r_height = val & 64'h1FFF;
			REG_BODY_WEIGHT:  r_weight = val & 64'h7FFF_FFFF;
			default: ;
		endcase
	endtask

	// Reprogram every register once the block has gone quiet
	task automatic apply_setting(input cfg_t c);
		hold_input();
		wait (pending_motion.size() == 0);
		repeat (DRAIN_CYC) @(negedge clk);
		write_reg(REG_BOUND_MODE, c.bound_mode);
		write_reg(REG_MAX_SPEED, c.max_speed);
		write_reg(REG_DECAY_FACTOR, c.decay_factor);
		write_reg(REG_EDGE_RADIUS, c.edge_radius);
		write_reg(REG_FIELD_WIDTH, c.field_width);
		write_reg(REG_FIELD_HEIGHT, c.field_height);
		write_reg(REG_BODY_WEIGHT, c.body_weight);
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	// Mostly moderate values near the field, some extremes and full-range noise
	function automatic word_t pick_word();
		case ($urandom_range(9))
			0, 1: return word_t'($urandom);
			2: begin
				case ($urandom_range(3))
					0: return 32'sh7FFF_FFFF;
					1: return 32'sh8000_0000;
					2: return 32'sh0;
					default: return -32'sd1;
				endcase
			end
			3, 4: return word_t'($urandom_range(32'h0800_0000)) - 32'sh0040_0000;
			default: return word_t'($urandom_range(32'h0008_0000)) - 32'sh0004_0000;
		endcase
	endfunction

	// Receiver: stall at random, decided at the falling edge
	always @(negedge clk) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(99) >= stall_pct);
		end
	end

	// Result checker: compare each taken result with the oldest prediction
	always @(posedge clk) begin
		out_item_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_motion.size() == 0) begin
				$error("unexpected tick result %h", out_item);
				fail_count++;
			end else begin
				want = pending_motion.pop_front();
				if (out_item.pos_x !== want.pos_x) begin
					$error("pos_x: expected %0d, got %0d", want.pos_x, out_item.pos_x);
					fail_count++;
				end
				if (out_item.pos_y !== want.pos_y) begin
					$error("pos_y: expected %0d, got %0d", want.pos_y, out_item.pos_y);
					fail_count++;
				end
				if (out_item.vel_x !== want.vel_x) begin
					$error("vel_x: expected %0d, got %0d", want.vel_x, out_item.vel_x);
					fail_count++;
				end
				if (out_item.vel_y !== want.vel_y) begin
					$error("vel_y: expected %0d, got %0d", want.vel_y, out_item.vel_y);
					fail_count++;
				end
			end
		end
	end

	// Directed table row: request, and a typed result where one is obvious
	typedef struct {
		in_item_t  req;
		bit        typed;
		out_item_t res;
	} plan_row_t;

	function automatic in_item_t mk(input logic [1:0] m, input word_t a, input word_t b,
			input word_t c, input word_t d);
		in_item_t it;
		it.mode = m;
		it.value_x = a;
		it.value_y = b;
		it.load_vel_x = c;
		it.load_vel_y = d;
		return it;
	endfunction

	initial begin
		plan_row_t plan[$];
		cfg_t      settings[N_PHASES];
		in_item_t  it;
		int        pick;
		word_t     wmax, wmin;

		wmax = 32'sh7FFF_FFFF;
		wmin = 32'sh8000_0000;
		fail_count = 0;
		send_idle_pct = 0;
		stall_pct = 0;
		in_valid = 1'b0;
		in_item = '0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_wdata = '0;
		body_px = 0; body_py = 0; body_vx = 0; body_vy = 0; body_ax = 0; body_ay = 0;
		r_bound = 0; r_vmax = 262144; r_decay = 65536; r_radius = 0;
		r_width = 1024; r_height = 768; r_weight = 65536;

		arst_n = 1'b0;
		repeat (8) @(negedge clk);
		arst_n = 1'b1;

		// Directed part under the reset settings
		plan.push_back('{mk(MODE_TICK, 0, 0, 0, 0), 1'b1, '0});
		plan.push_back('{mk(2'd3, wmax, wmin, wmax, wmin), 1'b0, '0});
		plan.push_back('{mk(MODE_TICK, wmax, wmax, wmax, wmax), 1'b1, '0});
		plan.push_back('{mk(MODE_FORCE, wmax, wmin, 0, 0), 1'b0, '0});
		plan.push_back('{mk(MODE_TICK, 0, 0, 0, 0), 1'b0, '0});
		plan.push_back('{mk(MODE_FORCE, wmin, wmax, wmax, wmin), 1'b0, '0});
		plan.push_back('{mk(MODE_TICK, 0, 0, 0, 0), 1'b0, '0});
		plan.push_back('{mk(MODE_LOAD, wmax, wmax, wmax, wmax), 1'b0, '0});
		plan.push_back('{mk(MODE_TICK, 0, 0, 0, 0), 1'b0, '0});
		plan.push_back('{mk(MODE_LOAD, wmin, wmin, wmin, wmin), 1'b0, '0});
		plan.push_back('{mk(MODE_TICK, 0, 0, 0, 0), 1'b0, '0});
		plan.push_back('{mk(MODE_LOAD, 32'sh0100_0000, 32'sh0100_0000, 32'sh0003_0000,
			-32'sh0003_0000), 1'b0, '0});
		plan.push_back('{mk(MODE_TICK, 0, 0, 0, 0), 1'b0, '0});
		plan.push_back('{mk(MODE_FORCE, 32'sh0001_0000, -32'sh0001_0000, 0, 0), 1'b0, '0});
		plan.push_back('{mk(MODE_TICK, 0, 0, 0, 0), 1'b0, '0});
		plan.push_back('{mk(MODE_LOAD, -32'sh0000_8000, 32'sh0300_8000, 0, 0), 1'b0, '0});
		plan.push_back('{mk(MODE_TICK, 0, 0, 0, 0), 1'b0, '0});
		plan.push_back('{mk(MODE_LOAD, 32'sh0401_0000, -32'sh0001_0000, 32'sh0002_0000,
			-32'sh0002_0000), 1'b0, '0});
		plan.push_back('{mk(MODE_TICK, 0, 0, 0, 0), 1'b0, '0});
		plan.push_back('{mk(2'd3, 0, 0, 0, 0), 1'b0, '0});
		plan.push_back('{mk(MODE_TICK, 0, 0, 0, 0), 1'b0, '0});
		foreach (plan[i])
			send_request(plan[i].req, plan[i].typed, plan[i].res);

		// Register settings: wrap, bounce, spring, no edge rule, and the extremes
		settings[0] = '{BOUND_WRAP,   31'd262144,     17'd65536,  10'd0,    13'd1024, 13'd768,
			31'd65536};
		settings[1] = '{BOUND_BOUNCE, 31'h7FFF_FFFF,  17'd0,      10'd1023, 13'd8191, 13'd8191,
			31'd1};
		settings[2] = '{BOUND_SPRING, 31'd655360,     17'd32768,  10'd5,    13'd64,   13'd48,
			31'd131072};
		settings[3] = '{2'd3,         31'd0,          17'h1_FFFF, 10'd1023, 13'd1,    13'd1,
			31'h7FFF_FFFF};
		settings[4] = '{BOUND_WRAP,   31'd100000,     17'd60000,  10'd1023, 13'd1,    13'd8191,
			31'd0};
		settings[5] = '{BOUND_BOUNCE, 31'd1048576,    17'd65536,  10'd3,    13'd20,   13'd20,
			31'd65536};
		settings[6] = '{BOUND_SPRING, 31'h7FFF_FFFF,  17'd65000,  10'd0,    13'd8191, 13'd1,
			31'd300};
		settings[7] = '{BOUND_WRAP,   31'd0,          17'd1,      10'd0,    13'd0,    13'd0,
			31'd65536};

		for (int ph = 0; ph < N_PHASES; ph++) begin
			apply_setting(settings[ph]);
			// Cycle through: no idling, sender idle, receiver stall, both
			case (ph % 4)
				0: begin send_idle_pct = 0;  stall_pct = 0;  end
				1: begin send_idle_pct = 72; stall_pct = 0;  end
				2: begin send_idle_pct = 0;  stall_pct = 72; end
				default: begin send_idle_pct = 14; stall_pct = 14; end
			endcase
			for (int n = 0; n < PER_PHASE; n++) begin
				if (n == PER_PHASE / 2 && ph == 2) begin
					hold_input();
					wait (pending_motion.size() == 0);
				end
				pick = $urandom_range(99);
				it.mode = (pick < 35) ? MODE_FORCE : (pick < 75) ? MODE_TICK :
					(pick < 93) ? MODE_LOAD : 2'd3;
				it.value_x = pick_word();
				it.value_y = pick_word();
				it.load_vel_x = pick_word();
				it.load_vel_y = pick_word();
				send_request(it, 1'b0, '0);
			end
		end

		// Drain, then let the block settle before the verdict
		hold_input();
		wait (pending_motion.size() == 0);
		repeat (DRAIN_CYC) @(posedge clk);
		if (fail_count == 0 && pending_motion.size() == 0) begin
			$display("tb_particle_motion_step_top OK");
		end else begin
			$display("tb_particle_motion_step_top NOT OK");
		end
		$finish;
	end

	// Watchdog: far beyond the slowest correct run
	initial begin
		#(64'd3_000_000 * (CLK_HI + CLK_LO));
		$display("tb_particle_motion_step_top NOT OK");
		$finish;
	end

endmodule

// File: filelist.f
rtl/pms_pkg.sv
rtl/pms_front.sv
rtl/pms_div.sv
rtl/pms_sqrt.sv
rtl/pms_back.sv
rtl/particle_motion_step_top.sv
bench/tb_particle_motion_step_top.sv
